>>> src/hedc_pkg.sv
package hedc_pkg;

    // Character codes used by the entity matcher and the collapse stage
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_QUOT  = 8'h22;  // '"'

    // Numeric entities give a byte only below this value
    localparam logic [10:0] CODE_LIMIT = 11'd128;

    // Depth of the queue between decoder and collapse stage
    localparam int QUEUE_DEPTH = 4;

    // Named entity selector
    localparam logic [1:0] NM_AMP  = 2'd0;
    localparam logic [1:0] NM_LT   = 2'd1;
    localparam logic [1:0] NM_GT   = 2'd2;
    localparam logic [1:0] NM_QUOT = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    // One queue entry: a decoded byte headed for the collapse stage
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;   // 0: marker only, closes an item with no byte
        logic       item_last;  // last entry caused by this request
        logic       text_end;   // request carried the end of the text
    } q_entry_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_AMP,
        MS_NAMED,
        MS_NUM0,
        MS_NUM_WS,
        MS_NUM_SIGN,
        MS_NUM_DIG
    } match_state_t;

    typedef enum logic [1:0] {
        FE_TAKE,
        FE_REPLAY,
        FE_DIRECT
    } fe_state_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
               (c == 8'h0D) || (c == 8'h0C) || (c == 8'h0B);
    endfunction

    // First letter after '&' of a named entity
    function automatic logic name_hit(input logic [7:0] c);
        return (c == 8'h61) || (c == 8'h6C) || (c == 8'h67) || (c == 8'h71);
    endfunction

    function automatic logic [1:0] name_sel(input logic [7:0] c);
        logic [1:0] k;
        unique case (c)
            8'h6C:   k = NM_LT;
            8'h67:   k = NM_GT;
            8'h71:   k = NM_QUOT;
            default: k = NM_AMP;
        endcase
        return k;
    endfunction

    // Expected byte at position pos of the entity name; zero past its end
    function automatic logic [7:0] name_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (k)
            NM_AMP: begin
                unique case (pos)
                    3'd0:    ch = 8'h61;  // a
                    3'd1:    ch = 8'h6D;  // m
                    3'd2:    ch = 8'h70;  // p
                    3'd3:    ch = CH_SEMI;
                    default: ch = 8'h00;
                endcase
            end
            NM_LT: begin
                unique case (pos)
                    3'd0:    ch = 8'h6C;  // l
                    3'd1:    ch = 8'h74;  // t
                    3'd2:    ch = CH_SEMI;
                    default: ch = 8'h00;
                endcase
            end
            NM_GT: begin
                unique case (pos)
                    3'd0:    ch = 8'h67;  // g
                    3'd1:    ch = 8'h74;  // t
                    3'd2:    ch = CH_SEMI;
                    default: ch = 8'h00;
                endcase
            end
            NM_QUOT: begin
                unique case (pos)
                    3'd0:    ch = 8'h71;  // q
                    3'd1:    ch = 8'h75;  // u
                    3'd2:    ch = 8'h6F;  // o
                    3'd3:    ch = 8'h74;  // t
                    3'd4:    ch = CH_SEMI;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] name_value(input logic [1:0] k);
        logic [7:0] v;
        unique case (k)
            NM_AMP:  v = CH_AMP;
            NM_LT:   v = CH_LT;
            NM_GT:   v = CH_GT;
            NM_QUOT: v = CH_QUOT;
            default: v = CH_AMP;
        endcase
        return v;
    endfunction

endpackage

>>> src/html_entity_decode_collapse.sv
// Throughput: the decoder takes one request per cycle while the queue is not full; when an
// entity breaks it replays its held bytes at one per cycle while the queue has room; the
// collapse stage handles each queue entry, inserted space and request close in turn.
// Reset: aresetn (synchronous, active low) clears matcher, queue and output state;
// the held-byte store is not cleared.
module html_entity_decode_collapse
    import hedc_pkg::*;
#(
    parameter int HOLD_DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    q_entry_t q_in;
    q_entry_t q_head;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;

    // Entity decoder
    hedc_front #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_data  (q_in),
        .q_full  (q_full)
    );

    // Decoupling queue
    hedc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // Whitespace collapse and result framing
    hedc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> src/hedc_fifo.sv
module hedc_fifo
    import hedc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output q_entry_t head,
    output logic     empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    q_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/hedc_front.sv
module hedc_front
    import hedc_pkg::*;
#(
    parameter int HOLD_DEPTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_push,
    output q_entry_t q_data,
    input  logic     q_full
);

    localparam int AW = $clog2(HOLD_DEPTH);
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    fe_state_t     fst_reg, fst_next;
    match_state_t  mst_reg;
    logic [CW-1:0] cnt_reg;
    logic [6:0]    code_reg;
    logic          neg_reg;
    logic          big_reg;
    logic [1:0]    k_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] rep_last_reg;
    logic          dir_pend_reg;
    logic [7:0]    dir_byte_reg;
    logic          item_end_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    hold_mem [HOLD_DEPTH];

    // Decision for the request at the input
    logic          accept;
    logic [7:0]    c;
    logic          e;
    logic          can_hold;
    logic          is_digit;
    logic          is_sign;
    logic [7:0]    exp_ch;
    logic [10:0]   dig_val;
    match_state_t  ms_upd;
    logic [CW-1:0] cnt_upd;
    logic [6:0]    code_upd;
    logic          neg_upd;
    logic          big_upd;
    logic [1:0]    k_upd;
    logic          hold_wr;
    logic          mism;
    logic          direct;
    logic [7:0]    dbyte;
    logic          replay;
    logic [CW-1:0] rep_last;
    logic          rep_done;
    logic [AW-1:0] rd_addr;

    assign c        = s_data.in_byte;
    assign e        = s_data.text_end;
    assign accept   = s_valid && s_ready;
    assign can_hold = (cnt_reg < CW'(HOLD_DEPTH));
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign exp_ch   = name_char(k_reg, 3'(cnt_reg - 1'b1));
    assign dig_val  = {1'b0, code_reg, 3'b000} + {3'b000, code_reg, 1'b0} + {7'd0, c[3:0]};
    assign rep_done = (idx_reg == rep_last_reg);

    // Entity matcher: classify the byte against the current match state
    always_comb begin
        ms_upd   = mst_reg;
        cnt_upd  = cnt_reg;
        code_upd = code_reg;
        neg_upd  = neg_reg;
        big_upd  = big_reg;
        k_upd    = k_reg;
        hold_wr  = 1'b0;
        mism     = 1'b0;
        direct   = 1'b0;
        dbyte    = c;
        replay   = 1'b0;
        rep_last = cnt_reg - 1'b1;

        unique case (mst_reg)
            MS_IDLE: begin
                if (c == CH_AMP) begin
                    ms_upd   = MS_AMP;
                    cnt_upd  = CW'(1);
                    code_upd = '0;
                    neg_upd  = 1'b0;
                    big_upd  = 1'b0;
                end else begin
                    direct = 1'b1;
                end
            end
            MS_AMP: begin
                if (name_hit(c) && can_hold) begin
                    hold_wr = 1'b1;
                    cnt_upd = cnt_reg + 1'b1;
                    k_upd   = name_sel(c);
                    ms_upd  = MS_NAMED;
                end else if ((c == CH_HASH) && can_hold) begin
                    hold_wr = 1'b1;
                    cnt_upd = cnt_reg + 1'b1;
                    ms_upd  = MS_NUM0;
                end else begin
                    mism = 1'b1;
                end
            end
            MS_NAMED: begin
                if ((c == exp_ch) && (exp_ch != 8'h00)) begin
                    if (c == CH_SEMI) begin
                        ms_upd  = MS_IDLE;
                        cnt_upd = '0;
                        direct  = 1'b1;
                        dbyte   = name_value(k_reg);
                    end else if (can_hold) begin
                        hold_wr = 1'b1;
                        cnt_upd = cnt_reg + 1'b1;
                    end else begin
                        mism = 1'b1;
                    end
                end else begin
                    mism = 1'b1;
                end
            end
            MS_NUM0, MS_NUM_WS: begin
                if ((c == CH_SEMI) && (mst_reg == MS_NUM0)) begin
                    // bare "&#;" is dropped
                    ms_upd   = MS_IDLE;
                    cnt_upd  = '0;
                    code_upd = '0;
                end else if (is_space(c) && can_hold) begin
                    hold_wr = 1'b1;
                    cnt_upd = cnt_reg + 1'b1;
                    ms_upd  = MS_NUM_WS;
                end else if (is_sign && can_hold) begin
                    hold_wr = 1'b1;
                    cnt_upd = cnt_reg + 1'b1;
                    neg_upd = (c == CH_MINUS);
                    ms_upd  = MS_NUM_SIGN;
                end else if (is_digit && can_hold) begin
                    hold_wr = 1'b1;
                    cnt_upd = cnt_reg + 1'b1;
                    ms_upd  = MS_NUM_DIG;
                    if (!big_reg) begin
                        if (dig_val >= CODE_LIMIT) big_upd = 1'b1;
                        else code_upd = dig_val[6:0];
                    end
                end else begin
                    mism = 1'b1;
                end
            end
            MS_NUM_SIGN, MS_NUM_DIG: begin
                if (is_digit && can_hold) begin
                    hold_wr = 1'b1;
                    cnt_upd = cnt_reg + 1'b1;
                    ms_upd  = MS_NUM_DIG;
                    if (!big_reg) begin
                        if (dig_val >= CODE_LIMIT) big_upd = 1'b1;
                        else code_upd = dig_val[6:0];
                    end
                end else if ((c == CH_SEMI) && (mst_reg == MS_NUM_DIG)) begin
                    ms_upd   = MS_IDLE;
                    cnt_upd  = '0;
                    code_upd = '0;
                    neg_upd  = 1'b0;
                    big_upd  = 1'b0;
                    direct   = !neg_reg && !big_reg && (code_reg != '0);
                    dbyte    = {1'b0, code_reg};
                end else begin
                    mism = 1'b1;
                end
            end
            default: begin
                mism = 1'b1;
            end
        endcase

        // Mismatch: replay the held bytes, then rescan the byte from idle
        if (mism) begin
            replay   = 1'b1;
            rep_last = cnt_reg - 1'b1;
            code_upd = '0;
            neg_upd  = 1'b0;
            big_upd  = 1'b0;
            if ((c == CH_AMP) && !e) begin
                ms_upd  = MS_AMP;
                cnt_upd = CW'(1);
            end else begin
                direct  = 1'b1;
                dbyte   = c;
                ms_upd  = MS_IDLE;
                cnt_upd = '0;
            end
        end else if (e && (ms_upd != MS_IDLE)) begin
            // Unfinished entity at end of text goes out literally
            if (hold_wr) begin
                replay   = 1'b1;
                rep_last = cnt_reg;
            end else begin
                direct = 1'b1;
                dbyte  = c;
            end
        end

        // End of text: matcher returns to reset
        if (e) begin
            ms_upd   = MS_IDLE;
            cnt_upd  = '0;
            code_upd = '0;
            neg_upd  = 1'b0;
            big_upd  = 1'b0;
        end
    end

    // Sequencer next state
    always_comb begin
        fst_next = fst_reg;
        unique case (fst_reg)
            FE_TAKE: begin
                if (accept && replay) fst_next = FE_REPLAY;
            end
            FE_REPLAY: begin
                if (!q_full && rep_done) fst_next = dir_pend_reg ? FE_DIRECT : FE_TAKE;
            end
            FE_DIRECT: begin
                if (!q_full) fst_next = FE_TAKE;
            end
            default: fst_next = FE_TAKE;
        endcase
    end

    // Sequencer outputs: queue pushes and replay index
    always_comb begin
        s_ready  = 1'b0;
        q_push   = 1'b0;
        q_data   = '{data: dbyte, has_byte: direct, item_last: 1'b1, text_end: e};
        idx_next = idx_reg;
        unique case (fst_reg)
            FE_TAKE: begin
                s_ready  = !q_full;
                q_push   = accept && !replay;
                idx_next = '0;
            end
            FE_REPLAY: begin
                q_push = !q_full;
                q_data = '{data: (idx_reg == '0) ? CH_AMP : rd_data_reg,
                           has_byte: 1'b1,
                           item_last: rep_done && !dir_pend_reg,
                           text_end: rep_done && !dir_pend_reg && item_end_reg};
                if (!q_full) idx_next = idx_reg + 1'b1;
            end
            FE_DIRECT: begin
                q_push = !q_full;
                q_data = '{data: dir_byte_reg, has_byte: 1'b1, item_last: 1'b1,
                           text_end: item_end_reg};
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Read address one step ahead so the registered read data tracks idx_reg
    assign rd_addr = (idx_next < CW'(HOLD_DEPTH)) ? idx_next[AW-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fst_reg      <= FE_TAKE;
            mst_reg      <= MS_IDLE;
            cnt_reg      <= '0;
            code_reg     <= '0;
            neg_reg      <= 1'b0;
            big_reg      <= 1'b0;
            idx_reg      <= '0;
            dir_pend_reg <= 1'b0;
        end else begin
            fst_reg <= fst_next;
            idx_reg <= idx_next;
            if (accept) begin
                mst_reg      <= ms_upd;
                cnt_reg      <= cnt_upd;
                code_reg     <= code_upd;
                neg_reg      <= neg_upd;
                big_reg      <= big_upd;
                dir_pend_reg <= direct;
            end
        end
    end

    // Request side payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            k_reg        <= k_upd;
            rep_last_reg <= rep_last;
            dir_byte_reg <= dbyte;
            item_end_reg <= e;
        end
    end

    // Held entity bytes; slot zero is never written, the replay supplies '&' in its place
    always_ff @(posedge aclk) begin
        if (accept && hold_wr) begin
            hold_mem[cnt_reg[AW-1:0]] <= c;
        end
        rd_data_reg <= hold_mem[rd_addr];
    end

endmodule

>>> src/hedc_back.sv
module hedc_back
    import hedc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  q_entry_t  q_head,
    input  logic      q_empty,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      stg_valid_reg, stg_valid_next;
    logic [7:0] stg_byte_reg, stg_byte_next;
    logic      close_reg, close_next;
    logic      close_end_reg, close_end_next;
    logic      space_reg, space_next;
    logic      emitted_reg, emitted_next;

    logic      out_free;
    logic      head_text;

    assign out_free  = !out_valid_reg || m_ready;
    assign head_text = q_head.has_byte && !is_space(q_head.data);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Collapse whitespace; the newest byte waits in a stage until the next
    // byte or the closing step tells whether it ends its request
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        stg_valid_next = stg_valid_reg;
        stg_byte_next  = stg_byte_reg;
        close_next     = close_reg;
        close_end_next = close_end_reg;
        space_next     = space_reg;
        emitted_next   = emitted_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && m_ready) out_valid_next = 1'b0;

        if (close_reg) begin
            // Close the request: mark the last result, or send a bare end
            if (stg_valid_reg || close_end_reg) begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{out_byte: stg_valid_reg ? stg_byte_reg : 8'h00,
                                       byte_valid: stg_valid_reg,
                                       run_last: 1'b1,
                                       string_end: close_end_reg};
                    stg_valid_next = 1'b0;
                    close_next     = 1'b0;
                    if (close_end_reg) begin
                        space_next   = 1'b0;
                        emitted_next = 1'b0;
                    end
                end
            end else begin
                close_next = 1'b0;
            end
        end else if (!q_empty) begin
            if (head_text) begin
                // A pending space goes out first, the byte on the next step
                if (!stg_valid_reg || out_free) begin
                    if (stg_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{out_byte: stg_byte_reg, byte_valid: 1'b1,
                                           run_last: 1'b0, string_end: 1'b0};
                    end
                    stg_valid_next = 1'b1;
                    if (space_reg) begin
                        stg_byte_next = CH_SPACE;
                        space_next    = 1'b0;
                    end else begin
                        stg_byte_next  = q_head.data;
                        emitted_next   = 1'b1;
                        q_pop          = 1'b1;
                        close_next     = q_head.item_last;
                        close_end_next = q_head.text_end;
                    end
                end
            end else begin
                // Whitespace or marker only
                q_pop          = 1'b1;
                close_next     = q_head.item_last;
                close_end_next = q_head.text_end;
                if (q_head.has_byte && emitted_reg) space_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            stg_valid_reg <= 1'b0;
            close_reg     <= 1'b0;
            close_end_reg <= 1'b0;
            space_reg     <= 1'b0;
            emitted_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            stg_valid_reg <= stg_valid_next;
            close_reg     <= close_next;
            close_end_reg <= close_end_next;
            space_reg     <= space_next;
            emitted_reg   <= emitted_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        stg_byte_reg <= stg_byte_next;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import hedc_pkg::*;

    localparam int HOLD_DEPTH = 16;
    localparam int QUIET_TAIL = 40;   // last requests run with no idling

    // One request of the stimulus, with an optional hand-typed result
    typedef struct packed {
        in_item_t  req;
        logic      typed;
        out_item_t want;
    } stim_t;

    localparam out_item_t NO_RES   = '0;
    localparam out_item_t BARE_END = '{out_byte: 8'h00, byte_valid: 1'b0,
                                       run_last: 1'b1, string_end: 1'b1};

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    html_entity_decode_collapse #(.HOLD_DEPTH(HOLD_DEPTH)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Directed requests; typed results only where obvious
    stim_t dir_rows [0:26] = '{
        '{'{8'h41, 1'b0}, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0}},  // first byte after reset
        '{'{8'h20, 1'b0}, 1'b0, NO_RES},
        '{'{CH_AMP, 1'b0}, 1'b0, NO_RES},                     // &lt;
        '{'{8'h6C, 1'b0}, 1'b0, NO_RES},
        '{'{8'h74, 1'b0}, 1'b0, NO_RES},
        '{'{CH_SEMI, 1'b0}, 1'b0, NO_RES},
        '{'{CH_AMP, 1'b0}, 1'b0, NO_RES},                     // bare &#;
        '{'{CH_HASH, 1'b0}, 1'b0, NO_RES},
        '{'{CH_SEMI, 1'b0}, 1'b0, NO_RES},
        '{'{CH_AMP, 1'b0}, 1'b0, NO_RES},                     // negative code
        '{'{CH_HASH, 1'b0}, 1'b0, NO_RES},
        '{'{CH_MINUS, 1'b0}, 1'b0, NO_RES},
        '{'{8'h35, 1'b0}, 1'b0, NO_RES},
        '{'{CH_SEMI, 1'b0}, 1'b0, NO_RES},
        '{'{CH_AMP, 1'b0}, 1'b0, NO_RES},                     // broken entity
        '{'{8'h78, 1'b0}, 1'b0, NO_RES},
        '{'{CH_AMP, 1'b0}, 1'b0, NO_RES},                     // unfinished at end
        '{'{8'h71, 1'b0}, 1'b0, NO_RES},
        '{'{8'h75, 1'b1}, 1'b0, NO_RES},
        '{'{8'h01, 1'b1}, 1'b1, '{8'h01, 1'b1, 1'b1, 1'b1}},  // lowest byte
        '{'{8'hFF, 1'b1}, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},  // highest byte
        '{'{8'h09, 1'b1}, 1'b1, BARE_END},                    // whitespace only
        '{'{CH_AMP, 1'b0}, 1'b0, NO_RES},                     // &#99;
        '{'{CH_HASH, 1'b0}, 1'b0, NO_RES},
        '{'{8'h39, 1'b0}, 1'b0, NO_RES},
        '{'{8'h39, 1'b0}, 1'b0, NO_RES},
        '{'{CH_SEMI, 1'b1}, 1'b0, NO_RES}
    };

    string      ent_name [4] = '{"amp;", "lt;", "gt;", "quot;"};
    logic [7:0] ent_val  [4] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT};
    logic [7:0] ws_set   [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};

    stim_t     stim_q [$];
    out_item_t decoded_q [$];   // decoded bytes still due on the output
    logic [7:0] step_bytes [$];

    int acc_idx  = 0;
    int err_cnt  = 0;
    bit quiet    = 1'b0;
    int rx_stall = 0;

    // Decoder state mirror
    match_state_t dec_state = MS_IDLE;
    logic [7:0]   hold_buf [HOLD_DEPTH];
    int           hold_cnt   = 0;
    int           code_val   = 0;
    bit           code_neg   = 1'b0;
    bit           code_big   = 1'b0;
    bit           space_pend = 1'b0;
    bit           any_out    = 1'b0;

    function automatic bit ws_byte(input logic [7:0] c);
        foreach (ws_set[i])
            if (c == ws_set[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int ent_index(input logic [7:0] c);
        for (int k = 0; k < 4; k++)
            if (ent_name[k][0] == c) return k;
        return -1;
    endfunction

    // Whitespace collapse stage
    function automatic void collapse_byte(input logic [7:0] c);
        if (ws_byte(c)) begin
            if (any_out) space_pend = 1'b1;
        end else begin
            if (space_pend) begin
                step_bytes.push_back(CH_SPACE);
                space_pend = 1'b0;
            end
            step_bytes.push_back(c);
            any_out = 1'b1;
        end
    endfunction

    function automatic void drop_match();
        hold_cnt  = 0;
        dec_state = MS_IDLE;
        code_val  = 0;
        code_neg  = 1'b0;
        code_big  = 1'b0;
    endfunction

    function automatic void replay_held();
        for (int i = 0; i < hold_cnt; i++)
            collapse_byte(hold_buf[i]);
        drop_match();
    endfunction

    function automatic bit hold_byte(input logic [7:0] c);
        if (hold_cnt >= HOLD_DEPTH) return 1'b0;
        hold_buf[hold_cnt] = c;
        hold_cnt++;
        return 1'b1;
    endfunction

    function automatic void start_idle(input logic [7:0] c);
        if (c == CH_AMP) begin
            drop_match();
            hold_buf[0] = CH_AMP;
            hold_cnt    = 1;
            dec_state   = MS_AMP;
        end else begin
            collapse_byte(c);
        end
    endfunction

    function automatic bit add_digit(input logic [7:0] c);
        int v;
        if (!hold_byte(c)) return 1'b0;
        if (!code_big) begin
            v = code_val * 10 + int'(c - CH_ZERO);
            if (v >= CODE_LIMIT) code_big = 1'b1;
            else code_val = v;
        end
        dec_state = MS_NUM_DIG;
        return 1'b1;
    endfunction

    // Entity matcher: one byte
    function automatic void match_byte(input logic [7:0] c);
        bit ok;
        bit dig;
        bit sgn;
        int k;
        int pos;
        logic [7:0] v;
        ok  = 1'b0;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        sgn = (c == CH_PLUS) || (c == CH_MINUS);
        case (dec_state)
            MS_AMP: begin
                if (ent_index(c) >= 0) begin
                    ok = hold_byte(c);
                    if (ok) dec_state = MS_NAMED;
                end else if (c == CH_HASH) begin
                    ok = hold_byte(c);
                    if (ok) dec_state = MS_NUM0;
                end
            end
            MS_NAMED: begin
                k   = ent_index(hold_buf[1]);
                pos = hold_cnt - 1;
                if (k >= 0 && pos < ent_name[k].len() && ent_name[k][pos] == c) begin
                    if (c == CH_SEMI) begin
                        drop_match();
                        collapse_byte(ent_val[k]);
                        return;
                    end
                    ok = hold_byte(c);
                end
            end
            MS_NUM0, MS_NUM_WS: begin
                if (c == CH_SEMI && dec_state == MS_NUM0) begin
                    drop_match();
                    return;
                end
                if (ws_byte(c)) begin
                    ok = hold_byte(c);
                    if (ok) dec_state = MS_NUM_WS;
                end else if (sgn) begin
                    ok = hold_byte(c);
                    if (ok) begin
                        code_neg  = (c == CH_MINUS);
                        dec_state = MS_NUM_SIGN;
                    end
                end else if (dig) begin
                    ok = add_digit(c);
                end
            end
            MS_NUM_SIGN: begin
                if (dig) ok = add_digit(c);
            end
            MS_NUM_DIG: begin
                if (dig) begin
                    ok = add_digit(c);
                end else if (c == CH_SEMI) begin
                    v = code_val[7:0];
                    if (!code_neg && !code_big && code_val > 0) begin
                        drop_match();
                        collapse_byte(v);
                    end else begin
                        drop_match();
                    end
                    return;
                end
            end
            default: begin
                start_idle(c);
                return;
            end
        endcase
        if (!ok) begin
            replay_held();
            start_idle(c);
        end
    endfunction

    // Work out the output of one request and queue it
    function automatic void decode_request(input in_item_t r);
        step_bytes.delete();
        match_byte(r.in_byte);
        if (r.text_end) begin
            if (dec_state != MS_IDLE) replay_held();
            space_pend = 1'b0;
        end
        if (step_bytes.size() == 0) begin
            if (r.text_end) decoded_q.push_back(BARE_END);
        end else begin
            foreach (step_bytes[k])
                decoded_q.push_back('{out_byte: step_bytes[k], byte_valid: 1'b1,
                                      run_last: k == step_bytes.size() - 1,
                                      string_end: k == step_bytes.size() - 1 && r.text_end});
        end
        if (r.text_end) begin
            drop_match();
            space_pend = 1'b0;
            any_out    = 1'b0;
        end
    endfunction

    // Stimulus building
    function automatic void push_byte(input logic [7:0] b);
        stim_q.push_back('{req: '{in_byte: b, text_end: 1'b0}, typed: 1'b0, want: NO_RES});
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void add_token();
        int kind;
        int n;
        int k;
        int cut;
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) push_byte(any_byte());
                    else push_byte(8'($urandom_range(8'h21, 8'h7E)));
                end
            end
            2: begin
                n = $urandom_range(1, 3);
                repeat (n) push_byte(ws_set[$urandom_range(0, 5)]);
            end
            3, 4, 5: begin
                // named entity, sometimes cut short and followed by noise
                k   = $urandom_range(0, 3);
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ent_name[k].len() - 1)
                                                  : ent_name[k].len();
                push_byte(CH_AMP);
                for (int i = 0; i < cut; i++) push_byte(ent_name[k][i]);
                if (cut < ent_name[k].len()) push_byte(any_byte());
            end
            6, 7, 8: begin
                // numeric entity: optional whitespace and sign, digits, then ';' or noise
                push_byte(CH_AMP);
                push_byte(CH_HASH);
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, 2);
                    repeat (n) push_byte(ws_set[$urandom_range(0, 5)]);
                end
                if ($urandom_range(0, 2) == 0)
                    push_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
                repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 7) == 0) push_byte(any_byte());
                else push_byte(CH_SEMI);
            end
            9: begin
                // long digit run, may overflow the hold store
                push_byte(CH_AMP);
                push_byte(CH_HASH);
                n = $urandom_range(12, 18);
                repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                push_byte(CH_SEMI);
            end
            10: begin
                push_byte(CH_AMP);
                push_byte(any_byte());
            end
            default: begin
                push_byte(CH_AMP);
                push_byte(CH_HASH);
                push_byte(CH_SEMI);
            end
        endcase
    endfunction

    function automatic void add_text();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) add_token();
        stim_q[stim_q.size() - 1].req.text_end = 1'b1;
    endfunction

    // Result ready with random stall bursts
    always @(posedge aclk) begin
        if (rx_stall > 0) rx_stall--;
        else if (!quiet && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 17);
        m_ready <= (rx_stall == 0);
    end

    // Predict on each accepted request, check each accepted result
    always @(posedge aclk) begin : chk
        out_item_t want;
        int        n0;
        if (aresetn && s_valid && s_ready) begin
            n0 = decoded_q.size();
            decode_request(stim_q[acc_idx].req);
            if (stim_q[acc_idx].typed) begin
                while (decoded_q.size() > n0) void'(decoded_q.pop_back());
                decoded_q.push_back(stim_q[acc_idx].want);
            end
            acc_idx++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: byte %h valid %b last %b end %b",
                             m_data.out_byte, m_data.byte_valid, m_data.run_last,
                             m_data.string_end);
            end else begin
                want = decoded_q.pop_front();
                if (m_data.out_byte !== want.out_byte || m_data.byte_valid !== want.byte_valid ||
                    m_data.run_last !== want.run_last ||
                    m_data.string_end !== want.string_end) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp byte %h valid %b last %b end %b, got %h %b %b %b",
                                 want.out_byte, want.byte_valid, want.run_last, want.string_end,
                                 m_data.out_byte, m_data.byte_valid, m_data.run_last,
                                 m_data.string_end);
                end
            end
        end
    end

    // Stimulus, request driver and end of run
    initial begin
        int gap;
        foreach (dir_rows[i]) stim_q.push_back(dir_rows[i]);
        while (stim_q.size() < 210) add_text();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < stim_q.size(); i++) begin
            if (i >= stim_q.size() - QUIET_TAIL) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 17);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= stim_q[i].req;
            do @(posedge aclk); while (!s_ready);
        end
        s_valid <= 1'b0;

        while (decoded_q.size() != 0 || acc_idx < stim_q.size()) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit
    initial begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
